// ===== rtl/ssd_pkg.sv =====
package ssd_pkg;

    localparam int MaxSamples    = 8192;
    localparam int WarmupSamples = 250;
    localparam int IdxW          = $clog2(MaxSamples);
    localparam int RunW          = IdxW + 1;
    localparam int CfgIdxW       = 3;
    localparam int CfgDataW      = 32;

    typedef enum logic [CfgIdxW-1:0] {
        REG_B0        = 3'd0,
        REG_B1        = 3'd1,
        REG_B2        = 3'd2,
        REG_A1        = 3'd3,
        REG_A2        = 3'd4,
        REG_THRESHOLD = 3'd5,
        REG_MIN_RUN   = 3'd6,
        REG_INIT      = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic               first;
        logic               last;
    } sample_t;

    typedef struct packed {
        logic [IdxW-1:0]    sample_index;
        logic signed [15:0] filtered_level;
        logic               quiet;
        logic               in_warmup;
        logic               segment_valid;
        logic [IdxW-1:0]    segment_start;
        logic [RunW-1:0]    segment_length;
    } result_t;

    typedef struct packed {
        logic [15:0] mag;
        logic        first;
        logic        last;
    } mag_word_t;

    typedef struct packed {
        logic signed [31:0] b0;
        logic signed [31:0] b1;
        logic signed [31:0] b2;
        logic signed [31:0] a1;
        logic signed [31:0] a2;
        logic [14:0]        threshold;
        logic [RunW-1:0]    min_run;
        logic [15:0]        init_level;
    } cfg_t;

endpackage

// ===== rtl/ssd_if.sv =====
interface ssd_sample_if;
    import ssd_pkg::*;
    logic    valid;
    logic    ready;
    sample_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ssd_result_if;
    import ssd_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ssd_front.sv =====
module ssd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    ssd_sample_if.sink           smp,
    output logic                 mag_valid,
    output ssd_pkg::mag_word_t   mag_word,
    input  logic                 mag_ready
);
    import ssd_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_SUM, F_ROOT, F_OUT} fstate_t;

    fstate_t     state_reg;
    logic [15:0] sq_a_reg, sq_b_reg, sq_c_reg;
    logic [31:0] rem_reg;
    logic [31:0] root_reg;
    logic [31:0] bit_reg;
    logic        first_reg, last_reg;
    logic [31:0] sq_sum;
    logic [31:0] trial;

    always_comb
    begin
        sq_sum = 32'($signed(sq_a_reg) * $signed(sq_a_reg))
               + 32'($signed(sq_b_reg) * $signed(sq_b_reg))
               + 32'($signed(sq_c_reg) * $signed(sq_c_reg));
        trial  = root_reg + bit_reg;
    end

    assign smp.ready = (state_reg == F_IDLE);
    assign mag_valid = (state_reg == F_OUT);
    assign mag_word  = '{mag: root_reg[15:0], first: first_reg, last: last_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (smp.valid)
                    begin
                        sq_a_reg  <= smp.data.accel_x;
                        sq_b_reg  <= smp.data.accel_y;
                        sq_c_reg  <= smp.data.accel_z;
                        first_reg <= smp.data.first;
                        last_reg  <= smp.data.last;
                        state_reg <= F_SUM;
                    end
                end
                F_SUM:
                begin
                    rem_reg   <= sq_sum;
                    root_reg  <= '0;
                    bit_reg   <= 32'h4000_0000;
                    state_reg <= F_ROOT;
                end
                F_ROOT:
                begin
                    if (rem_reg >= trial)
                    begin
                        rem_reg  <= rem_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                        state_reg <= F_OUT;
                end
                F_OUT:
                begin
                    if (mag_ready)
                        state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/ssd_queue.sv =====
module ssd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    input  ssd_pkg::mag_word_t wr_word,
    output logic               wr_ready,
    output logic               rd_valid,
    output ssd_pkg::mag_word_t rd_word,
    input  logic               rd_ready
);
    import ssd_pkg::*;

    mag_word_t   mem_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_word  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== rtl/ssd_back.sv =====
module ssd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  ssd_pkg::cfg_t      cfg,
    input  logic               mag_valid,
    input  ssd_pkg::mag_word_t mag_word,
    output logic               mag_ready,
    ssd_result_if.source       res
);
    import ssd_pkg::*;

    typedef enum logic [2:0] {B_IDLE, B_MAC, B_SUM, B_LVL, B_RUN, B_OUT} bstate_t;

    localparam logic [IdxW-1:0] IdxMax = IdxW'(MaxSamples - 1);
    localparam logic [RunW-1:0] RunMax = RunW'(MaxSamples);

    bstate_t            state_reg;
    logic [2:0]         tap_reg;
    logic [15:0]        mag_reg, in1_reg, in2_reg;
    logic signed [31:0] out1_reg, out2_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] ynew_reg;
    logic signed [15:0] lvl_reg;
    logic               last_reg;
    logic [IdxW-1:0]    idx_reg, cnt_idx_reg, begin_reg;
    logic [RunW-1:0]    run_reg;
    result_t            out_reg;

    logic signed [31:0] coef;
    logic signed [32:0] opnd;
    logic               fb_tap;
    logic signed [64:0] mult;
    logic signed [63:0] rnd;
    logic signed [63:0] ysh;
    logic signed [31:0] ysat;
    logic signed [32:0] lsh;
    logic signed [15:0] lsat;
    logic [15:0]        alvl;
    logic               quiet;
    logic [RunW-1:0]    run_inc;
    logic [IdxW-1:0]    begin_new;
    logic               flush;
    logic               seg_ok;
    logic [RunW-1:0]    min_eff;

    always_comb
    begin
        fb_tap = 1'b0;
        case (tap_reg)
            3'd0:
            begin
                coef = cfg.b0;
                opnd = {17'd0, mag_reg};
            end
            3'd1:
            begin
                coef = cfg.b1;
                opnd = {17'd0, in1_reg};
            end
            3'd2:
            begin
                coef = cfg.b2;
                opnd = {17'd0, in2_reg};
            end
            3'd3:
            begin
                coef   = cfg.a1;
                opnd   = {out1_reg[31], out1_reg};
                fb_tap = 1'b1;
            end
            default:
            begin
                coef   = cfg.a2;
                opnd   = {out2_reg[31], out2_reg};
                fb_tap = 1'b1;
            end
        endcase
        mult = 65'(coef * opnd);

        rnd  = acc_reg + 64'sd2097152;
        ysh  = rnd >>> 22;
        if (ysh > 64'sd2147483647)
            ysat = 32'h7FFF_FFFF;
        else if (ysh < -64'sd2147483648)
            ysat = 32'h8000_0000;
        else
            ysat = ysh[31:0];

        lsh = ($signed({ynew_reg[31], ynew_reg}) + 33'sd128) >>> 8;
        if (lsh > 33'sd32767)
            lsat = 16'sh7FFF;
        else if (lsh < -33'sd32768)
            lsat = 16'sh8000;
        else
            lsat = lsh[15:0];

        alvl  = lvl_reg[15] ? 16'(-lvl_reg) : 16'(lvl_reg);
        quiet = alvl < {1'b0, cfg.threshold};

        begin_new = begin_reg;
        run_inc   = run_reg;
        if (quiet)
        begin
            if (run_reg == '0)
                begin_new = idx_reg;
            if (run_reg < RunMax)
                run_inc = run_reg + 1'b1;
        end
        flush   = !quiet || last_reg;
        min_eff = (cfg.min_run == '0) ? RunW'(1) : cfg.min_run;
        seg_ok  = flush && (run_inc != '0) && (run_inc >= min_eff);
    end

    assign mag_ready = (state_reg == B_IDLE);
    assign res.valid = (state_reg == B_OUT) && (tap_reg != 3'd7);
    assign res.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            tap_reg     <= '0;
            in1_reg     <= 16'd4096;
            in2_reg     <= 16'd4096;
            out1_reg    <= '0;
            out2_reg    <= '0;
            cnt_idx_reg <= '0;
            run_reg     <= '0;
            begin_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    if (mag_valid)
                    begin
                        mag_reg  <= mag_word.mag;
                        last_reg <= mag_word.last;
                        acc_reg  <= '0;
                        tap_reg  <= '0;
                        if (mag_word.first)
                        begin
                            in1_reg   <= cfg.init_level;
                            in2_reg   <= cfg.init_level;
                            out1_reg  <= '0;
                            out2_reg  <= '0;
                            idx_reg   <= '0;
                            run_reg   <= '0;
                            begin_reg <= '0;
                        end
                        else
                        begin
                            idx_reg <= cnt_idx_reg;
                        end
                        state_reg <= B_MAC;
                    end
                end
                B_MAC:
                begin
                    prod_reg <= fb_tap ? 64'(mult >>> 8) : 64'(mult);
                    if (tap_reg != 3'd0)
                        acc_reg <= acc_reg + prod_reg;
                    tap_reg <= tap_reg + 1'b1;
                    if (tap_reg == 3'd4)
                        state_reg <= B_SUM;
                end
                B_SUM:
                begin
                    acc_reg   <= acc_reg + prod_reg;
                    state_reg <= B_LVL;
                end
                B_LVL:
                begin
                    ynew_reg  <= ysat;
                    in2_reg   <= in1_reg;
                    in1_reg   <= mag_reg;
                    out2_reg  <= out1_reg;
                    out1_reg  <= ysat;
                    state_reg <= B_RUN;
                end
                B_RUN:
                begin
                    lvl_reg   <= lsat;
                    state_reg <= B_OUT;
                    tap_reg   <= 3'd7;
                end
                B_OUT:
                begin
                    if (tap_reg == 3'd7)
                    begin
                        out_reg.sample_index   <= idx_reg;
                        out_reg.filtered_level <= lvl_reg;
                        out_reg.quiet          <= quiet;
                        out_reg.in_warmup      <= ({3'd0, idx_reg} < 16'(WarmupSamples));
                        out_reg.segment_valid  <= seg_ok;
                        out_reg.segment_start  <= seg_ok ? begin_new : '0;
                        out_reg.segment_length <= seg_ok ? run_inc : '0;
                        begin_reg <= begin_new;
                        run_reg   <= (flush) ? '0 : run_inc;
                        if (last_reg)
                            cnt_idx_reg <= '0;
                        else if (idx_reg < IdxMax)
                            cnt_idx_reg <= idx_reg + 1'b1;
                        else
                            cnt_idx_reg <= idx_reg;
                        tap_reg <= '0;
                    end
                    else if (res.ready)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/stationary_segment_detector.sv =====
// Path: an accepted word passes through the front end's square root into the queue,
// then through the back end's filter and run tracking to the result.
// Flow: the front end's bit-pair square root and the back end's five-tap shared
// multiplier each take one word at a time; a two-entry queue lets them overlap.
// Reset: asynchronous, active low; configuration registers return to their defaults,
// filter input history to 4096, output history and counters to zero.
module stationary_segment_detector (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ssd_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [ssd_pkg::CfgDataW-1:0]  cfg_data,
    ssd_sample_if.sink                    samples,
    ssd_result_if.source                  results
);
    import ssd_pkg::*;

    cfg_t      cfg_reg;
    logic      f_valid, f_ready, q_valid, q_ready;
    mag_word_t f_word, q_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.b0         <= 32'sd1073737053;
            cfg_reg.b1         <= -32'sd2147474106;
            cfg_reg.b2         <= 32'sd1073737053;
            cfg_reg.a1         <= 32'sd2147474107;
            cfg_reg.a2         <= -32'sd1073732283;
            cfg_reg.threshold  <= 15'd287;
            cfg_reg.min_run    <= RunW'(60);
            cfg_reg.init_level <= 16'd4096;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_B0:        cfg_reg.b0         <= cfg_data;
                REG_B1:        cfg_reg.b1         <= cfg_data;
                REG_B2:        cfg_reg.b2         <= cfg_data;
                REG_A1:        cfg_reg.a1         <= cfg_data;
                REG_A2:        cfg_reg.a2         <= cfg_data;
                REG_THRESHOLD: cfg_reg.threshold  <= cfg_data[14:0];
                REG_MIN_RUN:   cfg_reg.min_run    <= cfg_data[RunW-1:0];
                REG_INIT:      cfg_reg.init_level <= cfg_data[15:0];
                default:       cfg_reg.b0         <= cfg_reg.b0;
            endcase
        end
    end

    ssd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp       (samples),
        .mag_valid (f_valid),
        .mag_word  (f_word),
        .mag_ready (f_ready)
    );

    ssd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_word  (f_word),
        .wr_ready (f_ready),
        .rd_valid (q_valid),
        .rd_word  (q_word),
        .rd_ready (q_ready)
    );

    ssd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .mag_valid (q_valid),
        .mag_word  (q_word),
        .mag_ready (q_ready),
        .res       (results)
    );

    a_seg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.data.segment_valid |->
            results.data.segment_length == '0 && results.data.segment_start == '0)
        else $error("segment fields set without report");

    a_seg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.data.segment_valid |-> results.data.segment_length != '0)
        else $error("empty segment reported");

    a_queue_flow: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid && !f_ready |=> f_valid)
        else $error("magnitude dropped at queue");

endmodule
